@@ hw/rtl/tcle_pkg.sv @@
// Shared types and constants for the canonical line editor.
// Holds character codes, echo codes, register indexes and the request structs.
// No dependencies.
package tcle_pkg;

    // Control characters and escape sequence delimiters.
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] CH_EOT      = 8'h04;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_UPPER_O  = 8'h4F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_EN   = 2'd1;

    // Depth of the request queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [2:0] {
        ECHO_NONE  = 3'd0,
        ECHO_CHAR  = 3'd1,
        ECHO_ERASE = 3'd2,
        ECHO_INTR  = 3'd3,
        ECHO_BELL  = 3'd4
    } t_echo_kind;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_START = 2'd1,
        ESC_CSI   = 2'd2,
        ESC_CSI3  = 2'd3
    } t_esc_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_ECHO = 2'd1,
        BK_PASS = 2'd2,
        BK_LINE = 2'd3
    } t_back_state;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] dropped;
        logic [31:0] overflow;
        logic [31:0] escape;
    } t_counters;

    // One classified request: echo action, pass-through byte and counter snapshot.
    typedef struct packed {
        t_echo_kind  echo_kind;
        logic [7:0]  echo_char;
        logic        pass_valid;
        logic [7:0]  pass_char;
        t_counters   cnt;
    } t_job;

    typedef struct packed {
        logic        deliver_valid;
        logic [7:0]  deliver_char;
        t_echo_kind  echo_kind;
        logic [7:0]  echo_char;
        logic        last;
        t_counters   cnt;
    } t_result;

endpackage

@@ hw/rtl/tcle_front.sv @@
// Front end of the line editor: accepts received bytes, runs the escape filter,
// edits the line state and counters, and issues requests to the queue.
// Depends on tcle_pkg.
module tcle_front #(
    parameter int LINE_SIZE = 64,
    parameter int LEN_W     = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rx_valid,
    output logic                             o_rx_ready,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_cfg_valid,
    input  logic [tcle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                             i_cfg_data,
    input  logic                             i_q_full,
    input  logic                             i_line_done,
    output logic                             o_push,
    output tcle_pkg::t_job                   o_job,
    output logic [LEN_W-1:0]                 o_rel,
    output logic                             o_wr_en,
    output logic [LEN_W-1:0]                 o_wr_addr,
    output logic [7:0]                       o_wr_data
);
    import tcle_pkg::*;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_SIZE - 1);

    logic             r_line_mode, r_echo_en;
    logic [LEN_W-1:0] r_len, n_len;
    t_esc_phase       r_esc, n_esc;
    logic             r_trunc, n_trunc;
    t_counters        r_cnt, n_cnt;
    logic             r_rel_pending, n_rel_pending;
    logic             accept;
    t_echo_kind       ek;
    logic [7:0]       ec;

    // A release request blocks editing until the back end has read the line out.
    assign o_rx_ready = !i_q_full && !r_rel_pending;
    assign accept     = i_rx_valid && o_rx_ready;
    assign o_push     = accept;
    assign o_wr_data  = i_rx_byte;
    assign o_wr_addr  = r_len;

    // Classify the byte and compute the next line state.
    always_comb begin
        n_len         = r_len;
        n_esc         = r_esc;
        n_trunc       = r_trunc;
        n_cnt         = r_cnt;
        n_rel_pending = r_rel_pending && !i_line_done;
        ek            = ECHO_NONE;
        ec            = 8'h00;
        o_rel         = '0;
        o_wr_en       = 1'b0;
        o_job.pass_valid = 1'b0;
        o_job.pass_char  = 8'h00;
        if (accept) begin
            n_cnt.rx = r_cnt.rx + 32'd1;
            if (!r_line_mode) begin
                o_job.pass_valid = 1'b1;
                o_job.pass_char  = i_rx_byte;
                ek = ECHO_CHAR;
                ec = i_rx_byte;
            end else if (r_esc != ESC_IDLE || i_rx_byte == CH_ESC) begin
                // Escape filter swallows the byte.
                n_cnt.escape = r_cnt.escape + 32'd1;
                if (r_esc == ESC_IDLE) begin
                    n_esc = ESC_START;
                end else if (r_esc == ESC_START) begin
                    n_esc = (i_rx_byte == CH_LBRACKET || i_rx_byte == CH_UPPER_O) ?
                            ESC_CSI : ESC_IDLE;
                end else if (i_rx_byte inside {[CH_AT:CH_TILDE]}) begin
                    n_esc = ESC_IDLE;
                end
            end else begin
                case (i_rx_byte)
                    CH_ETX: begin
                        n_len = '0;
                        o_job.pass_valid = 1'b1;
                        o_job.pass_char  = i_rx_byte;
                        ek = ECHO_INTR;
                    end
                    CH_FF: begin
                        o_job.pass_valid = 1'b1;
                        o_job.pass_char  = i_rx_byte;
                    end
                    CH_BS, CH_DEL: begin
                        if (r_len != '0) begin
                            n_len = r_len - LEN_W'(1);
                            ek = ECHO_ERASE;
                        end
                    end
                    CH_LF: begin
                        if (r_len < LEN_LIMIT) begin
                            o_wr_en = 1'b1;
                            o_rel   = r_len + LEN_W'(1);
                        end else begin
                            n_cnt.dropped  = r_cnt.dropped + 32'd1;
                            n_cnt.overflow = r_cnt.overflow + 32'd1;
                            o_rel = r_len;
                        end
                        ek = ECHO_CHAR;
                        ec = i_rx_byte;
                        n_len   = '0;
                        n_trunc = 1'b0;
                    end
                    CH_EOT: begin
                        if (r_len == '0) begin
                            o_job.pass_valid = 1'b1;
                            o_job.pass_char  = i_rx_byte;
                        end else begin
                            o_rel = r_len;
                        end
                        n_len = '0;
                    end
                    default: begin
                        if (i_rx_byte >= CH_SPACE || i_rx_byte == CH_TAB) begin
                            if (r_len < LEN_LIMIT) begin
                                o_wr_en = 1'b1;
                                n_len = r_len + LEN_W'(1);
                                ek = ECHO_CHAR;
                                ec = i_rx_byte;
                            end else begin
                                n_cnt.dropped  = r_cnt.dropped + 32'd1;
                                n_cnt.overflow = r_cnt.overflow + 32'd1;
                                if (!r_trunc) begin
                                    ek = ECHO_BELL;
                                end
                                n_trunc = 1'b1;
                            end
                        end
                    end
                endcase
            end
            if (o_rel != '0) begin
                n_rel_pending = 1'b1;
            end
        end
        // Echo suppression and character cleanup.
        if (!r_echo_en) begin
            ek = ECHO_NONE;
        end
        o_job.echo_kind = ek;
        o_job.echo_char = (ek == ECHO_CHAR) ? ec : 8'h00;
        o_job.cnt       = n_cnt;
    end

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode   <= 1'b1;
            r_echo_en     <= 1'b1;
            r_len         <= '0;
            r_esc         <= ESC_IDLE;
            r_trunc       <= 1'b0;
            r_cnt         <= '0;
            r_rel_pending <= 1'b0;
        end else begin
            r_len         <= n_len;
            r_esc         <= n_esc;
            r_trunc       <= n_trunc;
            r_cnt         <= n_cnt;
            r_rel_pending <= n_rel_pending;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_LINE_MODE) begin
                    r_line_mode <= i_cfg_data;
                end else if (i_cfg_index == CFG_ECHO_EN) begin
                    r_echo_en <= i_cfg_data;
                end
            end
        end
    end

    // Stores only land below the last line slot.
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (o_wr_addr < LEN_LIMIT))
        else $error("line store write beyond line limit");

    // With echo off no request carries an echo action.
    a_echo_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !r_echo_en) |-> (o_job.echo_kind == ECHO_NONE))
        else $error("echo action issued while echo disabled");
endmodule

@@ hw/rtl/tcle_queue.sv @@
// Short request queue between the front and back parts of the line editor.
// Two entries of request plus release length, registered storage.
// Depends on tcle_pkg.
module tcle_queue #(
    parameter int LEN_W = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tcle_pkg::t_job      i_job,
    input  logic [LEN_W-1:0]    i_rel,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output tcle_pkg::t_job      o_job,
    output logic [LEN_W-1:0]    o_rel
);
    import tcle_pkg::*;

    localparam logic [Q_PTR_W:0] Q_FULL_CNT = (Q_PTR_W + 1)'(Q_DEPTH);

    t_job               r_job_q [Q_DEPTH];
    logic [LEN_W-1:0]   r_rel_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_FULL_CNT);
    assign o_job   = r_job_q[r_rd_ptr];
    assign o_rel   = r_rel_q[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job_q[r_wr_ptr] <= i_job;
            r_rel_q[r_wr_ptr] <= i_rel;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_PTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (Q_PTR_W + 1)'(1);
            end
        end
    end

    // The front end must never push into a full queue.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request queue overrun");
endmodule

@@ hw/rtl/tcle_back.sv @@
// Back end of the line editor: holds the line store, pops requests and
// emits the echo result, the pass-through byte and the released line bytes.
// Depends on tcle_pkg.
module tcle_back #(
    parameter int LINE_SIZE = 64,
    parameter int LEN_W     = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_pop,
    input  tcle_pkg::t_job      i_job,
    input  logic [LEN_W-1:0]    i_rel,
    input  logic                i_wr_en,
    input  logic [LEN_W-1:0]    i_wr_addr,
    input  logic [7:0]          i_wr_data,
    input  logic                i_res_ready,
    output logic                o_res_valid,
    output tcle_pkg::t_result   o_res,
    output logic                o_line_done
);
    import tcle_pkg::*;

    logic [7:0]       mem [LINE_SIZE];
    logic [7:0]       r_q;
    t_back_state      r_state, n_state;
    t_job             r_job, n_job;
    logic [LEN_W-1:0] r_rel, n_rel;
    logic [LEN_W-1:0] r_idx, n_idx;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic             load_ok;
    logic             line_last;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign load_ok     = !r_out_valid || i_res_ready;
    assign line_last   = ((r_idx + LEN_W'(1)) == r_rel);

    // Line store: one write port from the front, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= mem[n_idx];
    end

    // Sequencer next state and result selection.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rel       = r_rel;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        o_pop       = 1'b0;
        o_line_done = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_rel   = i_rel;
                    n_idx   = '0;
                    n_state = BK_ECHO;
                end
            end
            BK_ECHO: begin
                if (load_ok) begin
                    n_out_valid         = 1'b1;
                    n_out.deliver_valid = 1'b0;
                    n_out.deliver_char  = 8'h00;
                    n_out.echo_kind     = r_job.echo_kind;
                    n_out.echo_char     = r_job.echo_char;
                    n_out.last          = !r_job.pass_valid && (r_rel == '0);
                    n_out.cnt           = r_job.cnt;
                    if (r_job.pass_valid) begin
                        n_state = BK_PASS;
                    end else if (r_rel != '0) begin
                        n_state = BK_LINE;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_PASS: begin
                if (load_ok) begin
                    n_out_valid         = 1'b1;
                    n_out.deliver_valid = 1'b1;
                    n_out.deliver_char  = r_job.pass_char;
                    n_out.echo_kind     = ECHO_NONE;
                    n_out.echo_char     = 8'h00;
                    n_out.last          = (r_rel == '0);
                    n_out.cnt           = r_job.cnt;
                    n_state = (r_rel != '0) ? BK_LINE : BK_IDLE;
                end
            end
            BK_LINE: begin
                if (load_ok) begin
                    n_out_valid         = 1'b1;
                    n_out.deliver_valid = 1'b1;
                    n_out.deliver_char  = r_q;
                    n_out.echo_kind     = ECHO_NONE;
                    n_out.echo_char     = 8'h00;
                    n_out.last          = line_last;
                    n_out.cnt           = r_job.cnt;
                    if (line_last) begin
                        o_line_done = 1'b1;
                        n_state     = BK_IDLE;
                    end else begin
                        n_idx = r_idx + LEN_W'(1);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_rel <= n_rel;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A line walk only runs for a nonempty release.
    a_line_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_LINE) |-> (r_rel != '0))
        else $error("line walk with empty release");

    // The read index stays inside the released part of the line.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_LINE) |-> (r_idx < r_rel))
        else $error("line read index past release length");
endmodule

@@ hw/rtl/tty_canonical_line_editor_unit.sv @@
// Top level of the canonical line editor.
// Instantiates tcle_front, tcle_queue and tcle_back; depends on tcle_pkg.
//
// Usage:
//   Receive channel: one keyboard byte per request on i_rx_byte, taken when
//   i_rx_valid and o_rx_ready are both high.
//   Result channel: o_res_valid / i_res_ready. Each byte yields an echo result
//   first, then an optional pass-through byte, then any released line bytes;
//   o_last marks the final result of a byte.
//   Configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 selects line mode, index 1 echo enable, others are
//   ignored. Write only while the block is idle.
// Timing: a taken request is written into the request queue, popped into the
//   back job register, and its first result is then registered for output.
//   The back sequencer pops one request in its idle state, then issues its
//   results in order. Releases walk the line store at one read per cycle while
//   i_res_ready allows; the front takes no byte until the walk has finished.
// Reset: synchronous, active low; clears line state, counters and queue and
//   sets line mode and echo on. The line store needs no clearing pass.
// Stalls: when i_res_ready is low the result register holds, the back end
//   waits, and the two-entry request queue fills before o_rx_ready drops.
module tty_canonical_line_editor_unit #(
    parameter int LINE_SIZE = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rx_valid,
    output logic                             o_rx_ready,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                             i_cfg_data,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic                             o_deliver_valid,
    output logic [7:0]                       o_deliver_char,
    output logic [2:0]                       o_echo_kind,
    output logic [7:0]                       o_echo_char,
    output logic                             o_last,
    output logic [31:0]                      o_rx_total,
    output logic [31:0]                      o_dropped_total,
    output logic [31:0]                      o_overflow_total,
    output logic [31:0]                      o_escape_total
);
    import tcle_pkg::*;

    localparam int LEN_W = $clog2(LINE_SIZE);

    logic             push, pop, q_valid, q_full, line_done;
    t_job             f_job, q_job;
    logic [LEN_W-1:0] f_rel, q_rel;
    logic             wr_en;
    logic [LEN_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    t_result          res;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    tcle_front #(
        .LINE_SIZE (LINE_SIZE),
        .LEN_W     (LEN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .i_line_done (line_done),
        .o_push      (push),
        .o_job       (f_job),
        .o_rel       (f_rel),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    tcle_queue #(
        .LEN_W (LEN_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_rel   (f_rel),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job),
        .o_rel   (q_rel)
    );

    tcle_back #(
        .LINE_SIZE (LINE_SIZE),
        .LEN_W     (LEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_pop       (pop),
        .i_job       (q_job),
        .i_rel       (q_rel),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .o_res       (res),
        .o_line_done (line_done)
    );

    // Result fields onto their ports.
    assign o_deliver_valid  = res.deliver_valid;
    assign o_deliver_char   = res.deliver_char;
    assign o_echo_kind      = res.echo_kind;
    assign o_echo_char      = res.echo_char;
    assign o_last           = res.last;
    assign o_rx_total       = res.cnt.rx;
    assign o_dropped_total  = res.cnt.dropped;
    assign o_overflow_total = res.cnt.overflow;
    assign o_escape_total   = res.cnt.escape;
endmodule
